@@ sv/krlt_pkg.sv @@
// ----------------------------------------------------------------------------
// krlt_pkg
// Shared constants, codes and types of the key rate-limit table.
// ----------------------------------------------------------------------------
package krlt_pkg;

    localparam int ENTRIES_DEF  = 16;
    localparam int KEY_BITS_DEF = 64;
    localparam int SEC_BITS     = 32;
    localparam int ST_W         = 2;

    localparam logic [ST_W-1:0] ST_OK   = 2'd0;
    localparam logic [ST_W-1:0] ST_RATE = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL = 2'd2;

    localparam logic FUNC_CHECK   = 1'b0;
    localparam logic FUNC_TRIGGER = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_TAIL,
        S_EVAL,
        S_DONE
    } t_state;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clr_en;
    } t_mem_ctl;

endpackage

@@ sv/krlt_table.sv @@
// ----------------------------------------------------------------------------
// krlt_table
// Entry memory with registered read and per-entry valid bits;
// an entry that is not valid reads as all zero.
// ----------------------------------------------------------------------------
module krlt_table
    import krlt_pkg::*;
#(
    parameter int ENTRIES  = ENTRIES_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF,
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_mem_ctl            i_ctl,
    input  logic [IDX_W-1:0]    i_rd_addr,
    input  logic [IDX_W-1:0]    i_wr_addr,
    input  logic [IDX_W-1:0]    i_clr_addr,
    input  logic [KEY_BITS-1:0] i_wr_key,
    input  logic [SEC_BITS-1:0] i_wr_interval,
    input  logic [SEC_BITS-1:0] i_wr_last,
    output logic [KEY_BITS-1:0] o_rd_key,
    output logic [SEC_BITS-1:0] o_rd_interval,
    output logic [SEC_BITS-1:0] o_rd_last
);

    localparam int ENT_W = KEY_BITS + 2 * SEC_BITS;

    logic [ENT_W-1:0]   mem [ENTRIES];
    logic [ENT_W-1:0]   r_rd_data;
    logic               r_rd_vld;
    logic [ENTRIES-1:0] r_valid;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            mem[i_wr_addr] <= {i_wr_key, i_wr_interval, i_wr_last};
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_ctl.wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_ctl.clr_en) begin
                r_valid[i_clr_addr] <= 1'b0;
            end
            if (i_ctl.rd_en) begin
                r_rd_vld <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_key      = r_rd_vld ? r_rd_data[ENT_W-1 -: KEY_BITS]            : '0;
    assign o_rd_interval = r_rd_vld ? r_rd_data[2*SEC_BITS-1 -: SEC_BITS]       : '0;
    assign o_rd_last     = r_rd_vld ? r_rd_data[SEC_BITS-1:0]                   : '0;

endmodule

@@ sv/krlt_ctrl.sv @@
// ----------------------------------------------------------------------------
// krlt_ctrl
// Sequencer: sweeps the table once per word to expire entries and find the
// first match and first free entry, writes back if needed, registers status.
// ----------------------------------------------------------------------------
module krlt_ctrl
    import krlt_pkg::*;
#(
    parameter int ENTRIES  = ENTRIES_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF,
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_func,
    input  logic [63:0]         i_key_id,
    input  logic [SEC_BITS-1:0] i_min_interval,
    input  logic [SEC_BITS-1:0] i_now_sec,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [ST_W-1:0]     o_status,
    output t_mem_ctl            o_ctl,
    output logic [IDX_W-1:0]    o_rd_addr,
    output logic [IDX_W-1:0]    o_wr_addr,
    output logic [IDX_W-1:0]    o_clr_addr,
    output logic [KEY_BITS-1:0] o_wr_key,
    output logic [SEC_BITS-1:0] o_wr_interval,
    output logic [SEC_BITS-1:0] o_wr_last,
    input  logic [KEY_BITS-1:0] i_rd_key,
    input  logic [SEC_BITS-1:0] i_rd_interval,
    input  logic [SEC_BITS-1:0] i_rd_last
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    t_state              r_state, n_state;
    logic                r_func;
    logic [KEY_BITS-1:0] r_key;
    logic [SEC_BITS-1:0] r_min_int;
    logic [SEC_BITS-1:0] r_now;
    logic [IDX_W-1:0]    r_rd_idx;
    logic [IDX_W-1:0]    r_chk_idx;
    logic                r_dv;
    logic                r_m_found;
    logic [IDX_W-1:0]    r_m_idx;
    logic [SEC_BITS-1:0] r_m_last;
    logic [SEC_BITS-1:0] r_m_int;
    logic                r_f_found;
    logic [IDX_W-1:0]    r_f_idx;
    logic [SEC_BITS-1:0] r_f_last;
    logic                r_out_vld;
    logic [ST_W-1:0]     r_status;
    logic [ST_W-1:0]     r_res, n_res;

    logic                accept;
    logic                out_free;
    logic                load_out;
    logic                expired;
    logic [SEC_BITS:0]   exp_limit;
    logic [KEY_BITS-1:0] eff_key;
    logic [SEC_BITS-1:0] eff_int;
    logic [SEC_BITS-1:0] eff_last;
    logic                hit;
    logic                free;
    logic [SEC_BITS:0]   rate_sum;
    logic                rate_hit;
    logic                wr_en;

    assign accept   = (r_state == S_IDLE) && i_in_valid;
    assign out_free = !r_out_vld || i_out_ready;

    assign exp_limit = {1'b0, i_rd_last} + {1'b0, i_rd_interval};
    assign expired   = (i_rd_last != '0) && ({1'b0, r_now} >= exp_limit);
    assign eff_key   = expired ? '0 : i_rd_key;
    assign eff_int   = expired ? '0 : i_rd_interval;
    assign eff_last  = expired ? '0 : i_rd_last;
    assign hit       = (eff_key == r_key);
    assign free      = (eff_int == '0);

    assign rate_sum = {1'b0, r_m_last} + {1'b0, r_min_int};
    assign rate_hit = rate_sum > {1'b0, r_now};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_rd_idx == LAST_IDX) begin
                    n_state = S_TAIL;
                end
            end
            S_TAIL: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                n_state = out_free ? S_IDLE : S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_res         = ST_OK;
        wr_en         = 1'b0;
        o_wr_addr     = r_m_idx;
        o_wr_key      = r_key;
        o_wr_interval = r_m_int;
        o_wr_last     = r_now;
        if (r_func == FUNC_CHECK) begin
            if (r_m_found) begin
                n_res = rate_hit ? ST_RATE : ST_OK;
            end else if (r_f_found) begin
                wr_en         = 1'b1;
                o_wr_addr     = r_f_idx;
                o_wr_interval = r_min_int;
                o_wr_last     = r_f_last;
            end else begin
                n_res = ST_FULL;
            end
        end else begin
            wr_en = r_m_found;
        end
    end

    always_comb begin
        o_ctl.rd_en  = (r_state == S_SCAN);
        o_ctl.clr_en = r_dv && expired;
        o_ctl.wr_en  = (r_state == S_EVAL) && wr_en;
        o_in_ready   = (r_state == S_IDLE);
        load_out     = ((r_state == S_EVAL) || (r_state == S_DONE)) && out_free;
    end

    assign o_rd_addr  = r_rd_idx;
    assign o_clr_addr = r_chk_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_dv      <= 1'b0;
            r_out_vld <= 1'b0;
            r_m_found <= 1'b0;
            r_f_found <= 1'b0;
            r_rd_idx  <= '0;
        end else begin
            r_state <= n_state;
            r_dv    <= (r_state == S_SCAN);
            if (load_out) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
            if (accept) begin
                r_rd_idx  <= '0;
                r_m_found <= 1'b0;
                r_f_found <= 1'b0;
            end else begin
                if (r_state == S_SCAN && r_rd_idx != LAST_IDX) begin
                    r_rd_idx <= r_rd_idx + IDX_W'(1);
                end
                if (r_dv && hit && !r_m_found) begin
                    r_m_found <= 1'b1;
                end
                if (r_dv && free && !r_f_found) begin
                    r_f_found <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func    <= i_func;
            r_key     <= i_key_id[KEY_BITS-1:0];
            r_min_int <= i_min_interval;
            r_now     <= i_now_sec;
        end
        r_chk_idx <= r_rd_idx;
        if (r_dv && hit && !r_m_found) begin
            r_m_idx  <= r_chk_idx;
            r_m_last <= eff_last;
            r_m_int  <= eff_int;
        end
        if (r_dv && free && !r_f_found) begin
            r_f_idx  <= r_chk_idx;
            r_f_last <= eff_last;
        end
        if (r_state == S_EVAL) begin
            r_res <= n_res;
        end
        if (load_out) begin
            r_status <= (r_state == S_EVAL) ? n_res : r_res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_status    = r_status;

endmodule

@@ sv/key_rate_limit_table_unit.sv @@
// ----------------------------------------------------------------------------
// key_rate_limit_table_unit
// Key rate-limit table: expires stale entries, checks or registers a key,
// or stamps a key's last access second.
//
//   channel  direction  handshake                   payload
//   in       to block   i_in_valid / o_in_ready     i_func, i_key_id,
//                                                   i_min_interval, i_now_sec
//   out      from block o_out_valid / i_out_ready   o_status
//
// Each word passes from acceptance to a registered result through S_SCAN,
// one read per entry through the single read port of the entry memory, then
// S_TAIL for the last read data and S_EVAL to evaluate and write back.
// The next word is accepted in the cycle after the result is registered.
// Reset clears all entry valid bits at once; no clearing sweep is needed.
// A result waiting in the output register stalls the block only when the
// following word is ready to report.
// ----------------------------------------------------------------------------
module key_rate_limit_table_unit
    import krlt_pkg::*;
#(
    parameter int ENTRIES  = ENTRIES_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_func,
    input  logic [63:0]         i_key_id,
    input  logic [SEC_BITS-1:0] i_min_interval,
    input  logic [SEC_BITS-1:0] i_now_sec,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [ST_W-1:0]     o_status
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    t_mem_ctl            mem_ctl;
    logic [IDX_W-1:0]    rd_addr;
    logic [IDX_W-1:0]    wr_addr;
    logic [IDX_W-1:0]    clr_addr;
    logic [KEY_BITS-1:0] wr_key;
    logic [SEC_BITS-1:0] wr_interval;
    logic [SEC_BITS-1:0] wr_last;
    logic [KEY_BITS-1:0] rd_key;
    logic [SEC_BITS-1:0] rd_interval;
    logic [SEC_BITS-1:0] rd_last;

    krlt_ctrl #(
        .ENTRIES  (ENTRIES),
        .KEY_BITS (KEY_BITS)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_func         (i_func),
        .i_key_id       (i_key_id),
        .i_min_interval (i_min_interval),
        .i_now_sec      (i_now_sec),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_ctl          (mem_ctl),
        .o_rd_addr      (rd_addr),
        .o_wr_addr      (wr_addr),
        .o_clr_addr     (clr_addr),
        .o_wr_key       (wr_key),
        .o_wr_interval  (wr_interval),
        .o_wr_last      (wr_last),
        .i_rd_key       (rd_key),
        .i_rd_interval  (rd_interval),
        .i_rd_last      (rd_last)
    );

    krlt_table #(
        .ENTRIES  (ENTRIES),
        .KEY_BITS (KEY_BITS)
    ) u_table (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (mem_ctl),
        .i_rd_addr     (rd_addr),
        .i_wr_addr     (wr_addr),
        .i_clr_addr    (clr_addr),
        .i_wr_key      (wr_key),
        .i_wr_interval (wr_interval),
        .i_wr_last     (wr_last),
        .o_rd_key      (rd_key),
        .o_rd_interval (rd_interval),
        .o_rd_last     (rd_last)
    );

endmodule

@@ sv/krlt_checker.sv @@
// ----------------------------------------------------------------------------
// krlt_checker
// Port-level checks of the key rate-limit table, bound to the top level.
// ----------------------------------------------------------------------------
module krlt_checker
    import krlt_pkg::*;
(
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_valid,
    input logic            o_in_ready,
    input logic            o_out_valid,
    input logic            i_out_ready,
    input logic [ST_W-1:0] o_status
);

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == ST_OK || o_status == ST_RATE || o_status == ST_FULL))
        else $error("illegal status code");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status))
        else $error("stalled result changed");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready && !$rose(o_out_valid))
        else $error("word accepted without a sweep");

    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result raised while idle");

endmodule

bind key_rate_limit_table_unit krlt_checker u_krlt_checker (.*);

@@ tb/tb_key_rate_limit_table_unit.sv @@
// ----------------------------------------------------------------------------
// tb_key_rate_limit_table_unit
// Self-checking bench for the key rate-limit table. A status tracker keeps
// its own copy of the entry table and predicts the status of every accepted
// word. A directed opening covers the key, interval and second extremes, the
// zero key, a trigger at second zero, the wide sum compare and a full table.
// Random words from a small key pool follow under four idle/stall mixes, with
// one long output hold-off that backs the block up.
// ----------------------------------------------------------------------------
module tb_key_rate_limit_table_unit;
    import krlt_pkg::*;

    localparam int N_SLOT     = ENTRIES_DEF;
    localparam int POOL_SIZE  = 24;
    localparam int PHASE_LEN  = 263;
    localparam int HOLD_LEN   = 400;
    localparam int IDLE_LIMIT = 3000;
    localparam int DRAIN_WAIT = 3 * (N_SLOT + 3);
    localparam logic [SEC_BITS-1:0] SEC_MAX = '1;

    class key_limit_tracker;
        logic [63:0]         slot_key[N_SLOT];
        logic [SEC_BITS-1:0] slot_intv[N_SLOT];
        logic [SEC_BITS-1:0] slot_last[N_SLOT];
        logic [ST_W-1:0]     status_exp_q[$];
        int                  errors;
        int                  n_words;
        int                  n_ok;
        int                  n_rate;
        int                  n_full;

        function new();
            for (int i = 0; i < N_SLOT; i++) begin
                slot_key[i]  = '0;
                slot_intv[i] = '0;
                slot_last[i] = '0;
            end
            errors  = 0;
            n_words = 0;
            n_ok    = 0;
            n_rate  = 0;
            n_full  = 0;
        endfunction

        function void note_word(logic func, logic [63:0] key,
                                logic [SEC_BITS-1:0] intv, logic [SEC_BITS-1:0] now);
            logic [SEC_BITS:0] lim;
            logic [ST_W-1:0]   st;
            int                hit;
            int                free_slot;
            hit       = -1;
            free_slot = -1;
            st        = ST_OK;
            for (int i = 0; i < N_SLOT; i++) begin
                lim = {1'b0, slot_last[i]} + {1'b0, slot_intv[i]};
                if (slot_last[i] != '0 && {1'b0, now} >= lim) begin
                    slot_key[i]  = '0;
                    slot_intv[i] = '0;
                    slot_last[i] = '0;
                end
            end
            for (int i = 0; i < N_SLOT; i++) begin
                if (hit < 0 && slot_key[i] == key)
                    hit = i;
                if (free_slot < 0 && slot_intv[i] == '0)
                    free_slot = i;
            end
            if (func == FUNC_CHECK) begin
                if (hit >= 0) begin
                    lim = {1'b0, slot_last[hit]} + {1'b0, intv};
                    st  = (lim > {1'b0, now}) ? ST_RATE : ST_OK;
                end else if (free_slot < 0) begin
                    st = ST_FULL;
                end else begin
                    slot_key[free_slot]  = key;
                    slot_intv[free_slot] = intv;
                end
            end else if (hit >= 0) begin
                slot_last[hit] = now;
            end
            status_exp_q.push_back(st);
            n_words++;
        endfunction

        function void check_status(logic [ST_W-1:0] got);
            logic [ST_W-1:0] exp_st;
            if (status_exp_q.size() == 0) begin
                $error("status: unexpected word, got %0d", got);
                errors++;
            end else begin
                exp_st = status_exp_q.pop_front();
                if (got !== exp_st) begin
                    $error("status mismatch: expected %0d, got %0d", exp_st, got);
                    errors++;
                end
                if (exp_st == ST_OK)
                    n_ok++;
                else if (exp_st == ST_RATE)
                    n_rate++;
                else
                    n_full++;
            end
        endfunction

        function int pending();
            return status_exp_q.size();
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    logic                i_func;
    logic [63:0]         i_key_id;
    logic [SEC_BITS-1:0] i_min_interval;
    logic [SEC_BITS-1:0] i_now_sec;
    logic                o_out_valid;
    logic                i_out_ready;
    logic [ST_W-1:0]     o_status;

    key_limit_tracker    tracker;
    logic [63:0]         key_pool[POOL_SIZE];
    int                  send_idle_pct;
    int                  recv_stall_pct;
    bit                  hold_req;
    int                  idle_cycles;

    key_rate_limit_table_unit u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_func         (i_func),
        .i_key_id       (i_key_id),
        .i_min_interval (i_min_interval),
        .i_now_sec      (i_now_sec),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    task automatic offer_word(logic func, logic [63:0] key,
                              logic [SEC_BITS-1:0] intv, logic [SEC_BITS-1:0] now);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_func         <= func;
        i_key_id       <= key;
        i_min_interval <= intv;
        i_now_sec      <= now;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD_LEN - 1) @(negedge i_clk);
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready)
                tracker.note_word(i_func, i_key_id, i_min_interval, i_now_sec);
            if (o_out_valid && i_out_ready)
                tracker.check_status(o_status);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial begin
        logic [SEC_BITS-1:0] clock_sec;
        logic [SEC_BITS-1:0] intv;
        logic [63:0]         key;
        logic                func;
        int                  r;

        tracker        = new();
        idle_cycles    = 0;
        hold_req       = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_func         = FUNC_CHECK;
        i_key_id       = '0;
        i_min_interval = '0;
        i_now_sec      = '0;
        for (int i = 0; i < POOL_SIZE; i++)
            key_pool[i] = {$urandom, $urandom};
        key_pool[POOL_SIZE-1] = '0;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        offer_word(FUNC_CHECK, 64'd0, 32'd0, 32'd0);
        offer_word(FUNC_CHECK, 64'd0, 32'd3, 32'd0);
        offer_word(FUNC_TRIGGER, key_pool[20], 32'd9, 32'd5);
        offer_word(FUNC_CHECK, '1, 32'd1, 32'd7);
        offer_word(FUNC_TRIGGER, '1, 32'd0, SEC_MAX - 1);
        offer_word(FUNC_CHECK, '1, SEC_MAX, SEC_MAX - 1);
        offer_word(FUNC_CHECK, '1, 32'd0, SEC_MAX - 1);
        offer_word(FUNC_CHECK, key_pool[0], 32'd4, SEC_MAX);
        offer_word(FUNC_TRIGGER, key_pool[0], 32'd0, 32'd0);
        for (int i = 1; i <= N_SLOT; i++)
            offer_word(FUNC_CHECK, key_pool[i], i, 32'd10);

        clock_sec = 32'd1000;
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    hold_req       = 1'b1;
                end
                1: begin
                    send_idle_pct  = 66;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 66;
                end
                default: begin
                    send_idle_pct  = 19;
                    recv_stall_pct = 19;
                end
            endcase
            for (int n = 0; n < PHASE_LEN; n++) begin
                if ($urandom_range(99) < 12) begin
                    func = 1'($urandom_range(1));
                    key  = {$urandom, $urandom};
                    intv = (func == FUNC_TRIGGER) ? $urandom : 32'd0;
                    offer_word(func, key, intv, $urandom);
                end else begin
                    clock_sec = clock_sec + $urandom_range(0, 2);
                    if ($urandom_range(63) == 0)
                        clock_sec = clock_sec + $urandom_range(50, 5000);
                    r = $urandom_range(99);
                    if (r < 3)
                        intv = $urandom;
                    else if (r < 8)
                        intv = '0;
                    else
                        intv = $urandom_range(1, 40);
                    func = ($urandom_range(99) < 55) ? FUNC_CHECK : FUNC_TRIGGER;
                    offer_word(func, key_pool[$urandom_range(POOL_SIZE - 1)], intv,
                               clock_sec);
                end
            end
        end
        @(negedge i_clk);
        i_in_valid <= 1'b0;

        while (tracker.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Checked %0d words over four idle/stall mixes with one long output hold-off.",
                 tracker.n_words);
        $display("Statuses seen: %0d ok, %0d rate limited, %0d table full.",
                 tracker.n_ok, tracker.n_rate, tracker.n_full);
        if (tracker.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
